### design/matrix4_inverse_adjugate_top_assert.svh
// Assertion macros for the 4x4 adjugate inverse block.
// Included by matrix4_inverse_adjugate_top.sv; no other dependencies.
`ifndef MATRIX4_INVERSE_ADJUGATE_TOP_ASSERT_SVH
`define MATRIX4_INVERSE_ADJUGATE_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define M4I_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m4inv: same-cycle check failed");
// next-cycle implication
`define M4I_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m4inv: next-cycle check failed");
`else
`define M4I_ASSERT_IMP(label, clk, rst, ante, cons)
`define M4I_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### design/m4inv_pkg.sv
// Package for the 4x4 adjugate inverse: widths, sequencer states, MAC op type.
// No dependencies.
`default_nettype none
package m4inv_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ELEM_W = 32;
   localparam int PROD_W = 65;   // 32 x 33 signed product
   localparam int M2_W   = 65;   // 2x2 minor
   localparam int COF_W  = 104;  // 3x3 minor / cofactor
   localparam int ACC_W  = 136;  // determinant accumulator
   localparam int QBITS  = 33;   // quotient bits kept below the overflow test

   localparam logic [3:0] LAST_IDX  = 4'd15;
   localparam logic [5:0] PH_LAST   = 6'd5;   // last phase of a cofactor term
   localparam logic [5:0] TAIL_LAST = 6'd2;   // last count of the pipeline drain tail
   localparam logic [5:0] DET_LAST  = 6'd15;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_COF,
      ST_COF_TAIL,
      ST_DET,
      ST_DET_TAIL,
      ST_DIV_SETUP,
      ST_DIV,
      ST_PUT,
      ST_SING_RD,
      ST_SING_PUT
   } st_type;

   typedef enum logic [1:0] {
      BS_ELEM,
      BS_M2,
      BS_COF
   } bsel_type;

   typedef struct packed {
      logic       valid;
      logic       tgt_m2;
      logic       clr;
      logic       neg;
      bsel_type   bsel;
      logic [1:0] limb;
      logic [3:0] cidx;
   } mac_op_type;

   // index of the j-th of the three rows/cols left after dropping k
   function automatic logic [1:0] skip_idx(input logic [1:0] j, input logic [1:0] k);
      logic [1:0] r;
      r = (j >= k) ? 2'(j + 2'd1) : j;
      return r;
   endfunction

endpackage
`default_nettype wire

### design/matrix4_inverse_adjugate_top.sv
// 4x4 matrix inverse by adjugate: loader, shared MAC, restoring divider, output register.
// Depends on m4inv_pkg and matrix4_inverse_adjugate_top_assert.svh.
//
// Usage:
//  - req channel: 16 beats of req_element (signed Q16.16), row-major. The block takes
//    one beat per cycle while loading; req_stall is high from the beat after the 16th
//    element until the last result beat has been placed in the output register.
//  - rsp channel: 16 beats (rsp_value, rsp_singular, rsp_last), row-major; rsp_last
//    marks the 16th. A singular matrix (determinant exactly zero) comes back as loaded
//    with rsp_singular set on every beat.
//  - Per matrix: 16 load beats, then the 16 cofactors on one 32x33 signed multiplier,
//    limb by limb, then the determinant, then per result a restoring divider (one
//    quotient bit per cycle, 34 steps). A singular matrix skips the divider and
//    returns each loaded element directly.
//  - The divider dominates run time; the multiplier sets the cofactor phase.
//  - Reset (synchronous, active high) empties the output register and restarts loading
//    at element 0. The element store is not cleared; it is always fully written first.
//  - A stalled receiver holds the current result in the output register; the
//    sequencer waits there and resumes as soon as the beat is taken.
`default_nettype none
`include "matrix4_inverse_adjugate_top_assert.svh"

module matrix4_inverse_adjugate_top #(
   parameter int FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_element,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_singular,
   output logic               rsp_last
);

   localparam int ACC_W = m4inv_pkg::ACC_W;
   localparam int COF_W = m4inv_pkg::COF_W;
   localparam int PROD_W = m4inv_pkg::PROD_W;
   localparam int M2_W = m4inv_pkg::M2_W;
   localparam int QBITS = m4inv_pkg::QBITS;
   // numerator is |C| * 2^(2F+1) + |D|, divisor 2|D|
   localparam int SH = 2 * FRAC_BITS + 1;
   localparam int REM_W = ACC_W + SH + 1;
   localparam int DV_W = ACC_W + QBITS + 1;
   localparam int DIV_W = (REM_W > DV_W) ? REM_W : DV_W;

   // ---------------- sequencer state ----------------
   m4inv_pkg::st_type state_ff, state_in;
   logic [3:0] load_count_ff, load_count_in;
   logic [3:0] idx_ff, idx_in;      // cofactor / output index
   logic [1:0] term_ff, term_in;    // term of the 3x3 expansion
   logic [5:0] cnt_ff, cnt_in;      // phase / step counter

   // sequencer outputs
   logic mem_we, cof_we, det_we, div_setup, div_step, out_load, out_free;
   logic [3:0] addr_a, addr_b;
   m4inv_pkg::mac_op_type op0, op1_ff, op2_ff;

   // element store, two registered read ports
   logic [31:0] mem [16];
   logic signed [31:0] rd_a_ff;
   logic signed [31:0] rd_b_ff;

   // MAC datapath
   logic signed [32:0] b33;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [M2_W-1:0] m2_ff, m2_base, m2_in;
   logic signed [ACC_W-1:0] acc_ff, acc_base, acc_in, prod_ext, prod_shift;

   // cofactors and determinant
   logic [COF_W-1:0] cof_ff [16];
   logic [3:0] cof_addr;
   logic [COF_W-1:0] cof_rd, abs_c;
   logic [ACC_W-1:0] absd_ff;
   logic detneg_ff, sing_ff;

   // divider
   logic [DIV_W-1:0] rem_ff, dv_ff;
   logic [QBITS-1:0] q_ff;
   logic ovf_ff, neg_ff, ge;
   logic [31:0] div_val;

   // output register
   logic rsp_valid_ff, rsp_singular_ff, rsp_last_ff;
   logic [31:0] rsp_value_ff;

   // row/col selection for the current cofactor
   logic [1:0] x0, x1, x2, y0, y1, y2, yt, ya, yb;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      x0 = m4inv_pkg::skip_idx(2'd0, idx_ff[3:2]);
      x1 = m4inv_pkg::skip_idx(2'd1, idx_ff[3:2]);
      x2 = m4inv_pkg::skip_idx(2'd2, idx_ff[3:2]);
      y0 = m4inv_pkg::skip_idx(2'd0, idx_ff[1:0]);
      y1 = m4inv_pkg::skip_idx(2'd1, idx_ff[1:0]);
      y2 = m4inv_pkg::skip_idx(2'd2, idx_ff[1:0]);
      yt = (term_ff == 2'd0) ? y0 : ((term_ff == 2'd1) ? y1 : y2);
      ya = (term_ff == 2'd0) ? y1 : y0;
      yb = (term_ff == 2'd2) ? y1 : y2;
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         m4inv_pkg::ST_LOAD: begin
            if (req_valid && load_count_ff == m4inv_pkg::LAST_IDX)
               state_in = m4inv_pkg::ST_COF;
         end
         m4inv_pkg::ST_COF: begin
            if (cnt_ff == m4inv_pkg::PH_LAST && term_ff == 2'd2)
               state_in = m4inv_pkg::ST_COF_TAIL;
         end
         m4inv_pkg::ST_COF_TAIL: begin
            if (cnt_ff == m4inv_pkg::TAIL_LAST)
               state_in = (idx_ff == m4inv_pkg::LAST_IDX) ? m4inv_pkg::ST_DET
                                                          : m4inv_pkg::ST_COF;
         end
         m4inv_pkg::ST_DET: begin
            if (cnt_ff == m4inv_pkg::DET_LAST) state_in = m4inv_pkg::ST_DET_TAIL;
         end
         m4inv_pkg::ST_DET_TAIL: begin
            if (cnt_ff == m4inv_pkg::TAIL_LAST)
               state_in = (acc_ff == '0) ? m4inv_pkg::ST_SING_RD
                                         : m4inv_pkg::ST_DIV_SETUP;
         end
         m4inv_pkg::ST_DIV_SETUP: state_in = m4inv_pkg::ST_DIV;
         m4inv_pkg::ST_DIV: begin
            if (cnt_ff == 6'(QBITS)) state_in = m4inv_pkg::ST_PUT;
         end
         m4inv_pkg::ST_PUT: begin
            if (out_free)
               state_in = (idx_ff == m4inv_pkg::LAST_IDX) ? m4inv_pkg::ST_LOAD
                                                          : m4inv_pkg::ST_DIV_SETUP;
         end
         m4inv_pkg::ST_SING_RD: state_in = m4inv_pkg::ST_SING_PUT;
         m4inv_pkg::ST_SING_PUT: begin
            if (out_free)
               state_in = (idx_ff == m4inv_pkg::LAST_IDX) ? m4inv_pkg::ST_LOAD
                                                          : m4inv_pkg::ST_SING_RD;
         end
         default: state_in = m4inv_pkg::ST_LOAD;
      endcase
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req_stall = 1'b1;
      mem_we = 1'b0;
      cof_we = 1'b0;
      det_we = 1'b0;
      div_setup = 1'b0;
      div_step = 1'b0;
      out_load = 1'b0;
      load_count_in = load_count_ff;
      idx_in = idx_ff;
      term_in = term_ff;
      cnt_in = cnt_ff;
      addr_a = 4'd0;
      addr_b = 4'd0;
      op0 = '0;
      case (state_ff)
         m4inv_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mem_we = 1'b1;
               load_count_in = load_count_ff + 4'd1;
               idx_in = 4'd0;
               term_in = 2'd0;
               cnt_in = 6'd0;
            end
         end
         m4inv_pkg::ST_COF: begin
            // term: (-1)^t * e(x0,yt) * (e(x1,ya)e(x2,yb) - e(x1,yb)e(x2,ya))
            if (cnt_ff == 6'd0) begin
               addr_a = {x1, ya};
               addr_b = {x2, yb};
               op0.valid = 1'b1;
               op0.tgt_m2 = 1'b1;
               op0.clr = 1'b1;
               op0.bsel = m4inv_pkg::BS_ELEM;
            end else if (cnt_ff == 6'd1) begin
               addr_a = {x1, yb};
               addr_b = {x2, ya};
               op0.valid = 1'b1;
               op0.tgt_m2 = 1'b1;
               op0.neg = 1'b1;
               op0.bsel = m4inv_pkg::BS_ELEM;
            end else if (cnt_ff inside {[6'd3:6'd5]}) begin
               // cnt 2 is a bubble: the minor lands before its first limb is used
               addr_a = {x0, yt};
               op0.valid = 1'b1;
               op0.clr = (term_ff == 2'd0) && (cnt_ff == 6'd3);
               op0.neg = term_ff[0] ^ idx_ff[2] ^ idx_ff[0];
               op0.bsel = m4inv_pkg::BS_M2;
               op0.limb = 2'(cnt_ff - 6'd3);
            end
            if (cnt_ff == m4inv_pkg::PH_LAST) begin
               cnt_in = 6'd0;
               term_in = (term_ff == 2'd2) ? 2'd0 : term_ff + 2'd1;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         m4inv_pkg::ST_COF_TAIL: begin
            if (cnt_ff == m4inv_pkg::TAIL_LAST) begin
               cof_we = 1'b1;
               cnt_in = 6'd0;
               term_in = 2'd0;
               idx_in = idx_ff + 4'd1;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         m4inv_pkg::ST_DET: begin
            // det = sum over k of e(0,k) * cof(0,k), four limbs each
            addr_a = {2'd0, cnt_ff[3:2]};
            op0.valid = 1'b1;
            op0.clr = (cnt_ff == 6'd0);
            op0.bsel = m4inv_pkg::BS_COF;
            op0.limb = cnt_ff[1:0];
            op0.cidx = {2'd0, cnt_ff[3:2]};
            cnt_in = (cnt_ff == m4inv_pkg::DET_LAST) ? 6'd0 : cnt_ff + 6'd1;
         end
         m4inv_pkg::ST_DET_TAIL: begin
            if (cnt_ff == m4inv_pkg::TAIL_LAST) begin
               det_we = 1'b1;
               cnt_in = 6'd0;
               idx_in = 4'd0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         m4inv_pkg::ST_DIV_SETUP: begin
            div_setup = 1'b1;
            cnt_in = 6'd0;
         end
         m4inv_pkg::ST_DIV: begin
            div_step = 1'b1;
            cnt_in = (cnt_ff == 6'(QBITS)) ? 6'd0 : cnt_ff + 6'd1;
         end
         m4inv_pkg::ST_PUT: begin
            if (out_free) begin
               out_load = 1'b1;
               idx_in = idx_ff + 4'd1;
            end
         end
         m4inv_pkg::ST_SING_RD: begin
            addr_a = idx_ff;
         end
         m4inv_pkg::ST_SING_PUT: begin
            addr_a = idx_ff;
            if (out_free) begin
               out_load = 1'b1;
               idx_in = idx_ff + 4'd1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= m4inv_pkg::ST_LOAD;
         load_count_ff <= 4'd0;
         idx_ff <= 4'd0;
         term_ff <= 2'd0;
         cnt_ff <= 6'd0;
         op1_ff <= '0;
         op2_ff <= '0;
      end else begin
         state_ff <= state_in;
         load_count_ff <= load_count_in;
         idx_ff <= idx_in;
         term_ff <= term_in;
         cnt_ff <= cnt_in;
         op1_ff <= op0;
         op2_ff <= op1_ff;
      end
   end

   // ---------------- element store ----------------
   always_ff @(posedge clock) begin
      if (mem_we) mem[load_count_ff] <= req_element;
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // ---------------- shared multiplier (stage 1) ----------------
   assign cof_addr = (state_ff == m4inv_pkg::ST_DIV_SETUP) ? {idx_ff[1:0], idx_ff[3:2]}
                                                           : op1_ff.cidx;
   assign cof_rd = cof_ff[cof_addr];

   always_comb begin
      b33 = '0;
      case (op1_ff.bsel)
         m4inv_pkg::BS_ELEM: b33 = {rd_b_ff[31], rd_b_ff};
         m4inv_pkg::BS_M2: begin
            case (op1_ff.limb)
               2'd0: b33 = {1'b0, m2_ff[31:0]};
               2'd1: b33 = {1'b0, m2_ff[63:32]};
               default: b33 = {33{m2_ff[M2_W-1]}};
            endcase
         end
         m4inv_pkg::BS_COF: begin
            case (op1_ff.limb)
               2'd0: b33 = {1'b0, cof_rd[31:0]};
               2'd1: b33 = {1'b0, cof_rd[63:32]};
               2'd2: b33 = {1'b0, cof_rd[95:64]};
               default: b33 = {{(33 - (COF_W - 96)){cof_rd[COF_W-1]}}, cof_rd[COF_W-1:96]};
            endcase
         end
         default: b33 = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= rd_a_ff * b33;
   end

   // ---------------- accumulate (stage 2) ----------------
   always_comb begin
      prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      prod_shift = prod_ext << {op2_ff.limb, 5'd0};
      m2_base = op2_ff.clr ? '0 : m2_ff;
      acc_base = op2_ff.clr ? '0 : acc_ff;
      m2_in = op2_ff.neg ? (m2_base - prod_ff) : (m2_base + prod_ff);
      acc_in = op2_ff.neg ? (acc_base - prod_shift) : (acc_base + prod_shift);
   end

   always_ff @(posedge clock) begin
      if (op2_ff.valid) begin
         if (op2_ff.tgt_m2) m2_ff <= m2_in;
         else acc_ff <= acc_in;
      end
      if (cof_we) cof_ff[idx_ff] <= acc_ff[COF_W-1:0];
      if (det_we) begin
         absd_ff <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
         detneg_ff <= acc_ff[ACC_W-1];
         sing_ff <= (acc_ff == '0);
      end
   end

   // ---------------- divider ----------------
   assign abs_c = cof_rd[COF_W-1] ? COF_W'(~cof_rd + COF_W'(1)) : cof_rd;
   assign ge = (rem_ff >= dv_ff);

   always_ff @(posedge clock) begin
      if (div_setup) begin
         rem_ff <= (DIV_W'(abs_c) << SH) + DIV_W'(absd_ff);
         dv_ff <= DIV_W'(absd_ff) << (QBITS + 1);
         q_ff <= '0;
         ovf_ff <= 1'b0;
         neg_ff <= cof_rd[COF_W-1] ^ detneg_ff;
      end else if (div_step) begin
         dv_ff <= dv_ff >> 1;
         if (cnt_ff == 6'd0) begin
            // quotient would need more than QBITS bits
            ovf_ff <= ge;
         end else begin
            if (ge) rem_ff <= rem_ff - dv_ff;
            q_ff <= {q_ff[QBITS-2:0], ge};
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || q_ff > {2'b01, 31'd0}) div_val = 32'h8000_0000;
         else div_val = 32'(~q_ff[31:0] + 32'd1);
      end else begin
         if (ovf_ff || q_ff[QBITS-1] || q_ff[31]) div_val = 32'h7FFF_FFFF;
         else div_val = q_ff[31:0];
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= sing_ff ? rd_a_ff : div_val;
         rsp_singular_ff <= sing_ff;
         rsp_last_ff <= (idx_ff == m4inv_pkg::LAST_IDX);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_singular = rsp_singular_ff;
   assign rsp_last = rsp_last_ff;

   // ---------------- assertions ----------------
   `M4I_ASSERT_NXT(a_stall_after_last, clock, reset, req_valid && !req_stall && load_count_ff == m4inv_pkg::LAST_IDX, req_stall)
   `M4I_ASSERT_IMP(a_count_idle, clock, reset, state_ff != m4inv_pkg::ST_LOAD, load_count_ff == 4'd0)
   `M4I_ASSERT_IMP(a_cof_drained, clock, reset, cof_we, !op1_ff.valid && !op2_ff.valid)

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for matrix4_inverse_adjugate_top (4x4 inverse by adjugate).
// Depends on m4inv_pkg and the top-level RTL; the predictor is a small scoreboard class.
`timescale 1ns / 100ps
`default_nettype none

module tb;

   // wide enough for cofactors (~97 bits) and the determinant (~130 bits)
   typedef logic signed [199:0] wide_type;

   typedef struct {
      logic [31:0] value;
      bit          singular;
      bit          last;
   } inv_beat_type;

   // Scoreboard: mirrors the element store, predicts the 16 result beats of
   // each matrix and compares them in order.
   class inverse_scoreboard;
      logic signed [31:0] store[16];
      int                 load_idx;
      inv_beat_type       expected_q[$];
      int                 matrices;
      int                 singulars;
      int                 checked;

      function new();
         load_idx = 0;
         matrices = 0;
         singulars = 0;
         checked = 0;
      endfunction

      // signed cofactor of row r, column c
      function wide_type cofactor(int r, int c);
         wide_type e[9];
         wide_type m;
         int       k;
         k = 0;
         for (int x = 0; x < 4; x++) begin
            if (x != r) begin
               for (int y = 0; y < 4; y++) begin
                  if (y != c) begin
                     e[k] = store[x*4+y];
                     k++;
                  end
               end
            end
         end
         m = e[0] * (e[4]*e[8] - e[5]*e[7])
           - e[1] * (e[3]*e[8] - e[5]*e[6])
           + e[2] * (e[3]*e[7] - e[4]*e[6]);
         return ((r + c) % 2 == 1) ? -m : m;
      endfunction

      // round(c * 2^(2F) / d), ties away from zero, saturated to 32 bits
      function logic [31:0] scaled_div(wide_type c, wide_type d);
         logic [255:0] an, ad, q;
         bit           neg;
         neg = (c < 0) != (d < 0);
         an = (c < 0) ? -c : c;
         ad = (d < 0) ? -d : d;
         an = (an << (2*m4inv_pkg::FRAC_BITS_DEF + 1)) + ad;
         q = an / (ad << 1);
         if (neg) begin
            if (q > 256'h8000_0000) return 32'h8000_0000;
            return 32'(-q);
         end
         if (q > 256'h7FFF_FFFF) return 32'h7FFF_FFFF;
         return q[31:0];
      endfunction

      function void note_element(logic signed [31:0] elem);
         wide_type     cof[16];
         wide_type     det;
         inv_beat_type b;
         bit           sing;
         store[load_idx] = elem;
         load_idx = (load_idx + 1) % 16;
         if (load_idx != 0) return;
         for (int k = 0; k < 16; k++) cof[k] = cofactor(k / 4, k % 4);
         det = 0;
         for (int k = 0; k < 4; k++) det = det + wide_type'(store[k]) * cof[k];
         sing = (det == 0);
         matrices++;
         if (sing) singulars++;
         for (int k = 0; k < 16; k++) begin
            b.value = sing ? store[k] : scaled_div(cof[(k % 4)*4 + k / 4], det);
            b.singular = sing;
            b.last = (k == 15);
            expected_q.push_back(b);
         end
      endfunction

      // returns an empty string on a match, else a description
      function string check_beat(logic [31:0] v, logic s, logic l);
         inv_beat_type e;
         if (expected_q.size() == 0)
            return $sformatf("unexpected beat value=%h singular=%b last=%b", v, s, l);
         e = expected_q.pop_front();
         checked++;
         if (v !== e.value || s !== e.singular || l !== e.last)
            return $sformatf("beat %0d: got value=%h singular=%b last=%b, want %h %b %b",
                             checked, v, s, l, e.value, e.singular, e.last);
         return "";
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_element = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic               rsp_singular;
   logic               rsp_last;

   inverse_scoreboard sb = new();
   int                mismatches = 0;
   logic [31:0]       mat_buf[16];
   bit                long_hold_req = 0;   // sender asks receiver for a long hold-off
   bit                hold_done = 0;

   always #5 clock = ~clock;

   matrix4_inverse_adjugate_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_element (req_element),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_value   (rsp_value),
      .rsp_singular(rsp_singular),
      .rsp_last    (rsp_last)
   );

   task automatic report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Monitor: values sampled at the edge are the pre-update ones, so both
   // channels are seen exactly as the block saw them.
   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_element(req_element);
         if (rsp_valid && !rsp_stall) begin
            msg = sb.check_beat(rsp_value, rsp_singular, rsp_last);
            if (msg != "") report(msg);
         end
      end
   end

   // Receiver: stall pattern drawn per phase from four modes; a long hold-off on request.
   initial begin
      int mode;
      int phase_cnt;
      int hold_cnt;
      mode = 0;
      phase_cnt = 0;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req && hold_cnt == 0 && !hold_done) begin
            hold_cnt = 3000;
            hold_done = 1;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else begin
            if (phase_cnt == 0) begin
               mode = $urandom_range(0, 3);
               phase_cnt = 64;
            end
            phase_cnt--;
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;                       // no back-pressure
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 9) < 3);
               end
               2: begin
                  rsp_stall <= ($urandom_range(0, 9) < 8);  // heavy
               end
               default: begin
                  rsp_stall <= (phase_cnt % 5 < 2);         // periodic
               end
            endcase
         end
      end
   end

   // Sender state for bursty input
   int  burst_left = 0;
   bit  no_gaps = 0;

   task automatic send_beat(input logic [31:0] v);
      if (!no_gaps && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_element <= v;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_matrix();
      for (int i = 0; i < 16; i++) send_beat(mat_buf[i]);
   endtask

   task automatic rand_matrix(input int kind);
      for (int i = 0; i < 16; i++) begin
         case (kind)
            0: mat_buf[i] = $urandom();
            1: mat_buf[i] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: mat_buf[i] = (i / 4 == i % 4) ? $urandom_range(1, 40) *
                            (($urandom_range(0, 1) == 1) ? 1 : -1) : 0;
            default: mat_buf[i] = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
         endcase
      end
      // singular: last row copies the first, or a zero column
      if (kind == 3) begin
         if ($urandom_range(0, 1) == 1)
            for (int j = 0; j < 4; j++) mat_buf[12+j] = mat_buf[j];
         else
            for (int j = 0; j < 4; j++) mat_buf[j*4+1] = 0;
      end
   endtask

   initial begin
      int kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: singular rows built from field extremes
      for (int i = 0; i < 16; i++)
         case (i % 4)
            0: mat_buf[i] = 32'h8000_0000;
            1: mat_buf[i] = 32'h7FFF_FFFF;
            2: mat_buf[i] = 32'hFFFF_FFFF;
            default: mat_buf[i] = 32'h0;
         endcase
      no_gaps = 1;
      send_matrix();
      // directed: diagonal with tiny and extreme entries -> saturation both ways
      for (int i = 0; i < 16; i++) mat_buf[i] = 0;
      mat_buf[0] = 32'h1;
      mat_buf[5] = 32'hFFFF_FFFF;
      mat_buf[10] = 32'h7FFF_FFFF;
      mat_buf[15] = 32'h8000_0000;
      send_matrix();

      for (int m = 0; m < 12; m++) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         kind = (m < 4) ? m : $urandom_range(0, 3);
         rand_matrix(kind);
         if (m == 4) long_hold_req = 1;    // block fills while receiver is held
         send_matrix();
         if (m == 7) begin
            // let everything drain before continuing; the first clock wait lets the
            // monitor note the last accepted beat
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
            repeat (20) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d matrices (%0d singular), %0d result beats checked.",
               sb.matrices, sb.singulars, sb.checked);
      if (mismatches == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d beats outstanding", sb.pending());
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
